/* rtl/hcbp_pkg.sv */
`default_nettype none

package hcbp_pkg;

  localparam int SYM_W    = 8;
  localparam int CODE_W   = 32;
  localparam int LEN_W    = 6;
  localparam int KIND_W   = 2;
  localparam int STATUS_W = 2;
  localparam int BYTE_W   = 8;
  localparam int PAD_W    = 3;
  localparam int TOTAL_W  = 32;

  localparam int PEND_W  = 7;               // at most seven bits wait for a byte
  localparam int CNT_W   = 3;
  localparam int ACC_W   = PEND_W + CODE_W; // pending bits plus one full code
  localparam int NBITS_W = 6;               // bit count in the accumulator, up to ACC_W

  localparam int MAX_CODE_LEN_DEF   = 32;
  localparam int SYMBOL_COUNT_DEF   = 256;
  localparam int CMD_FIFO_DEPTH_DEF = 4;

  localparam logic [KIND_W-1:0] KIND_LOAD   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ENCODE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_FLUSH  = 2'd2;

  localparam logic [STATUS_W-1:0] STATUS_DATA  = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FLUSH = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_MISS  = 2'd2;

  typedef enum logic [1:0] {
    OP_ENCODE,
    OP_MISS,
    OP_FLUSH
  } cmd_op_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [SYM_W-1:0]  symbol;
    logic [CODE_W-1:0] code_word;
    logic [LEN_W-1:0]  code_length;
  } in_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [BYTE_W-1:0]   out_byte;
    logic                byte_valid;
    logic [PAD_W-1:0]    pad_bits;
    logic [TOTAL_W-1:0]  total_bytes;
    logic                last_of_run;
  } out_item_t;

  typedef struct packed {
    cmd_op_t           op;
    logic [CODE_W-1:0] code;
    logic [LEN_W-1:0]  len;
  } cmd_t;

endpackage

`default_nettype wire

/* rtl/huffman_code_bit_packer.sv */
`default_nettype none

// Huffman code bit packer. Load beats fill a per-symbol code table (length 0
// invalidates an entry), encode beats append the symbol's code MSB first and
// emit each completed byte, flush beats report the zero-padded last byte with
// pad count and stream byte total. The front end takes one beat per cycle
// unless a command waits on a full queue: loads finish there, encodes and
// flushes go through a 4-entry queue to the packer, which takes a command
// only when idle, so an encode ends before the next starts. An encode emits
// its completed bytes as the output register frees (a 32-bit code can complete
// four bytes); flush and miss commands report there when taken. That
// byte-per-cycle packer into the single output register sets the sustained
// rate. The table needs no clearing pass: its valid bits reset at once.
module huffman_code_bit_packer #(
  parameter int MAX_CODE_LEN   = hcbp_pkg::MAX_CODE_LEN_DEF,
  parameter int SYMBOL_COUNT   = hcbp_pkg::SYMBOL_COUNT_DEF,
  parameter int CMD_FIFO_DEPTH = hcbp_pkg::CMD_FIFO_DEPTH_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                push,
  output logic                     full,
  input  wire hcbp_pkg::in_item_t  in_data,
  output logic                     empty,
  input  wire logic                pop,
  output hcbp_pkg::out_item_t      out_data
);

  logic           q_push, q_full, q_pop, q_empty;
  hcbp_pkg::cmd_t q_wdata, q_rdata;
  logic           out_valid;

  hcbp_front #(
    .MAX_CODE_LEN(MAX_CODE_LEN),
    .SYMBOL_COUNT(SYMBOL_COUNT)
  ) u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .full   (full),
    .in_data(in_data),
    .q_push (q_push),
    .q_full (q_full),
    .q_data (q_wdata)
  );

  hcbp_cmd_fifo #(
    .DEPTH(CMD_FIFO_DEPTH)
  ) u_cmd_fifo (
    .clk  (clk),
    .rst_n(rst_n),
    .push (q_push),
    .wdata(q_wdata),
    .full (q_full),
    .pop  (q_pop),
    .rdata(q_rdata),
    .empty(q_empty)
  );

  hcbp_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_data   (q_rdata),
    .q_empty  (q_empty),
    .q_pop    (q_pop),
    .out_valid(out_valid),
    .out_data (out_data),
    .pop      (pop)
  );

  assign empty = !out_valid;

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full)
    else $error("command pushed into full queue");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty)
    else $error("command popped from empty queue");

  a_data_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_data.status == hcbp_pkg::STATUS_DATA) |->
      (out_data.byte_valid && out_data.pad_bits == '0 && out_data.total_bytes == '0))
    else $error("data byte beat with bad side fields");

  a_empty_flush: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_data.status == hcbp_pkg::STATUS_FLUSH && !out_data.byte_valid) |->
      (out_data.pad_bits == '0 && out_data.out_byte == '0))
    else $error("flush report without data has nonzero byte or pad");

endmodule

`default_nettype wire

/* rtl/hcbp_front.sv */
`default_nettype none

module hcbp_front #(
  parameter int MAX_CODE_LEN = hcbp_pkg::MAX_CODE_LEN_DEF,
  parameter int SYMBOL_COUNT = hcbp_pkg::SYMBOL_COUNT_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  output logic                   full,
  input  wire hcbp_pkg::in_item_t in_data,
  output logic                   q_push,
  input  wire logic              q_full,
  output hcbp_pkg::cmd_t         q_data
);

  localparam int IDX_W = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;
  localparam int ROW_W = hcbp_pkg::LEN_W + MAX_CODE_LEN;
  localparam logic [hcbp_pkg::SYM_W:0] SYM_LIMIT =
    (hcbp_pkg::SYM_W + 1)'(SYMBOL_COUNT);
  localparam logic [hcbp_pkg::LEN_W-1:0] MAX_LEN = hcbp_pkg::LEN_W'(MAX_CODE_LEN);

  // code table: length in the upper bits, code word below
  logic [ROW_W-1:0]        mem [SYMBOL_COUNT];
  logic [SYMBOL_COUNT-1:0] valid_r, valid_nxt;
  logic [ROW_W-1:0]        rd_r;
  logic                    hit_r;
  logic                    s1_valid_r, s1_valid_nxt;
  logic                    s1_flush_r;

  logic                        accept;
  logic [IDX_W-1:0]            idx;
  logic                        in_range;
  logic                        is_load;
  logic [hcbp_pkg::LEN_W-1:0]  len_clamp;
  logic [hcbp_pkg::LEN_W-1:0]  rd_len;
  logic [hcbp_pkg::CODE_W-1:0] rd_code;
  logic [hcbp_pkg::CODE_W-1:0] code_mask;

  assign accept    = push && !full;
  assign idx       = in_data.symbol[IDX_W-1:0];
  assign in_range  = {1'b0, in_data.symbol} < SYM_LIMIT;
  assign is_load   = accept && (in_data.kind == hcbp_pkg::KIND_LOAD) && in_range;
  assign len_clamp = (in_data.code_length > MAX_LEN) ? MAX_LEN : in_data.code_length;

  assign q_push = s1_valid_r && !q_full;
  assign full   = s1_valid_r && q_full;

  always_comb begin
    valid_nxt = valid_r;
    if (is_load) begin
      valid_nxt[idx] = (in_data.code_length != '0);
    end
  end

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (accept) begin
      s1_valid_nxt = (in_data.kind == hcbp_pkg::KIND_ENCODE) ||
                     (in_data.kind == hcbp_pkg::KIND_FLUSH);
    end else if (q_push) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      valid_r    <= valid_nxt;
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (is_load && (in_data.code_length != '0)) begin
      mem[idx] <= {len_clamp, in_data.code_word[MAX_CODE_LEN-1:0]};
    end
    if (accept) begin
      rd_r       <= mem[idx];
      hit_r      <= in_range && valid_r[idx];
      s1_flush_r <= (in_data.kind == hcbp_pkg::KIND_FLUSH);
    end
  end

  assign rd_len    = rd_r[ROW_W-1 -: hcbp_pkg::LEN_W];
  assign rd_code   = hcbp_pkg::CODE_W'(rd_r[MAX_CODE_LEN-1:0]);
  assign code_mask = ~({hcbp_pkg::CODE_W{1'b1}} << rd_len);

  always_comb begin
    q_data.op   = s1_flush_r ? hcbp_pkg::OP_FLUSH
                : (hit_r ? hcbp_pkg::OP_ENCODE : hcbp_pkg::OP_MISS);
    q_data.code = rd_code & code_mask;
    q_data.len  = rd_len;
  end

endmodule

`default_nettype wire

/* rtl/hcbp_cmd_fifo.sv */
`default_nettype none

module hcbp_cmd_fifo #(
  parameter int DEPTH = hcbp_pkg::CMD_FIFO_DEPTH_DEF
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push,
  input  wire hcbp_pkg::cmd_t  wdata,
  output logic                 full,
  input  wire logic            pop,
  output hcbp_pkg::cmd_t       rdata,
  output logic                 empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  hcbp_pkg::cmd_t   slots [DEPTH];
  logic [PTR_W-1:0] wptr_r, wptr_nxt;
  logic [PTR_W-1:0] rptr_r, rptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == FULL_CNT);
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = slots[rptr_r];

  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    cnt_nxt  = cnt_r;
    if (do_push) begin
      wptr_nxt = (wptr_r == LAST_PTR) ? '0 : wptr_r + 1'b1;
    end
    if (do_pop) begin
      rptr_nxt = (rptr_r == LAST_PTR) ? '0 : rptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wptr_r] <= wdata;
    end
  end

endmodule

`default_nettype wire

/* rtl/hcbp_back.sv */
`default_nettype none

module hcbp_back (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire hcbp_pkg::cmd_t  q_data,
  input  wire logic            q_empty,
  output logic                 q_pop,
  output logic                 out_valid,
  output hcbp_pkg::out_item_t  out_data,
  input  wire logic            pop
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  localparam logic [hcbp_pkg::NBITS_W-1:0] BYTE_BITS = hcbp_pkg::NBITS_W'(8);
  localparam logic [hcbp_pkg::NBITS_W-1:0] TWO_BYTES = hcbp_pkg::NBITS_W'(16);

  logic                          state_r, state_nxt;
  logic [hcbp_pkg::ACC_W-1:0]    acc_r, acc_nxt;
  logic [hcbp_pkg::NBITS_W-1:0]  n_r, n_nxt;
  logic [hcbp_pkg::PEND_W-1:0]   pend_bits_r, pend_bits_nxt;
  logic [hcbp_pkg::CNT_W-1:0]    pend_cnt_r, pend_cnt_nxt;
  logic [hcbp_pkg::TOTAL_W-1:0]  byte_cnt_r, byte_cnt_nxt;
  logic                          out_valid_r, out_valid_nxt;
  hcbp_pkg::out_item_t           out_data_r, out_data_nxt;

  logic                          slot_free;
  logic [hcbp_pkg::NBITS_W-1:0]  n_less;
  logic [hcbp_pkg::CNT_W-1:0]    fin_cnt;
  logic [hcbp_pkg::BYTE_W-1:0]   flush_byte;
  logic [hcbp_pkg::PAD_W-1:0]    flush_pad;

  assign slot_free = !out_valid_r || pop;
  assign n_less    = n_r - BYTE_BITS;
  assign q_pop     = (state_r == ST_IDLE) && !q_empty && slot_free;

  // partial byte, left-justified; pending bits above the count are zero
  assign flush_byte = hcbp_pkg::BYTE_W'({1'b0, pend_bits_r} << (4'd8 - {1'b0, pend_cnt_r}));
  assign flush_pad  = hcbp_pkg::PAD_W'(4'd8 - {1'b0, pend_cnt_r});

  always_comb begin
    state_nxt     = state_r;
    acc_nxt       = acc_r;
    n_nxt         = n_r;
    pend_bits_nxt = pend_bits_r;
    pend_cnt_nxt  = pend_cnt_r;
    byte_cnt_nxt  = byte_cnt_r;
    out_valid_nxt = out_valid_r && !pop;
    out_data_nxt  = out_data_r;
    fin_cnt       = n_r[hcbp_pkg::CNT_W-1:0];

    unique case (state_r)
      ST_IDLE: begin
        if (q_pop) begin
          case (q_data.op)
            hcbp_pkg::OP_ENCODE: begin
              acc_nxt = (hcbp_pkg::ACC_W'(pend_bits_r) << q_data.len) |
                        hcbp_pkg::ACC_W'(q_data.code);
              n_nxt   = hcbp_pkg::NBITS_W'(pend_cnt_r) + hcbp_pkg::NBITS_W'(q_data.len);
              state_nxt = ST_RUN;
            end
            hcbp_pkg::OP_FLUSH: begin
              out_valid_nxt            = 1'b1;
              out_data_nxt             = '0;
              out_data_nxt.status      = hcbp_pkg::STATUS_FLUSH;
              out_data_nxt.last_of_run = 1'b1;
              out_data_nxt.total_bytes = byte_cnt_r;
              if (pend_cnt_r != '0) begin
                out_data_nxt.out_byte    = flush_byte;
                out_data_nxt.byte_valid  = 1'b1;
                out_data_nxt.pad_bits    = flush_pad;
                out_data_nxt.total_bytes = byte_cnt_r + 1'b1;
              end
              pend_bits_nxt = '0;
              pend_cnt_nxt  = '0;
              byte_cnt_nxt  = '0;
            end
            default: begin
              out_valid_nxt            = 1'b1;
              out_data_nxt             = '0;
              out_data_nxt.status      = hcbp_pkg::STATUS_MISS;
              out_data_nxt.last_of_run = 1'b1;
            end
          endcase
        end
      end
      ST_RUN: begin
        if (n_r < BYTE_BITS) begin
          // code left no full byte
          pend_bits_nxt = acc_r[hcbp_pkg::PEND_W-1:0] &
                          ~({hcbp_pkg::PEND_W{1'b1}} << fin_cnt);
          pend_cnt_nxt  = fin_cnt;
          state_nxt     = ST_IDLE;
        end else if (slot_free) begin
          out_valid_nxt            = 1'b1;
          out_data_nxt             = '0;
          out_data_nxt.status      = hcbp_pkg::STATUS_DATA;
          out_data_nxt.out_byte    = hcbp_pkg::BYTE_W'(acc_r >> n_less);
          out_data_nxt.byte_valid  = 1'b1;
          out_data_nxt.last_of_run = (n_r < TWO_BYTES);
          byte_cnt_nxt             = byte_cnt_r + 1'b1;
          n_nxt                    = n_less;
          if (n_r < TWO_BYTES) begin
            fin_cnt       = n_less[hcbp_pkg::CNT_W-1:0];
            pend_bits_nxt = acc_r[hcbp_pkg::PEND_W-1:0] &
                            ~({hcbp_pkg::PEND_W{1'b1}} << fin_cnt);
            pend_cnt_nxt  = fin_cnt;
            state_nxt     = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pend_bits_r <= '0;
      pend_cnt_r  <= '0;
      byte_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pend_bits_r <= pend_bits_nxt;
      pend_cnt_r  <= pend_cnt_nxt;
      byte_cnt_r  <= byte_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r      <= acc_nxt;
    n_r        <= n_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire
